@@ hdl/rfc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_pkg
// Types, constants and the byte-wide CRC step shared by the frame checker.
// ----------------------------------------------------------------------------
package rfc_pkg;

    localparam logic [7:0]  MAGIC_FIRST  = 8'h42;
    localparam logic [7:0]  MAGIC_SECOND = 8'h4C;
    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [15:0] CRC_INIT     = 16'hFFFF;
    localparam logic [7:0]  HEADER_BYTES = 8'd8;
    localparam logic [8:0]  MIN_FRAME    = 9'd10;   // header plus two CRC bytes
    localparam logic [8:0]  FULL_COUNT   = 9'd256;  // total reported once saturated

    // register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_VERSION = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_LOWEST      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TYPE_HIGHEST     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_FIRST     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_SECOND    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD      = 3'd5;

    localparam int OUT_DATA_W = 64;

    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_SHORT        = 4'd1,
        ERR_MAGIC        = 4'd2,
        ERR_VERSION      = 4'd3,
        ERR_TYPE         = 4'd4,
        ERR_SOURCE       = 4'd5,
        ERR_PAYLOAD_LONG = 4'd6,
        ERR_LENGTH       = 4'd7,
        ERR_CRC          = 4'd8
    } err_code_t;

    // one classified byte, front to back
    typedef struct packed {
        logic [7:0]  data;
        logic        feed_crc;     // byte goes into the running CRC
        logic        emit;         // pass on as a payload item
        logic [7:0]  index;        // payload position
        logic        is_end;       // verdict item
        err_code_t   code;         // verdict before the CRC compare
        logic [7:0]  crc_low;      // received CRC low byte
        logic [7:0]  frame_type;
        logic [7:0]  frame_source;
        logic [15:0] sequence_no;
        logic [7:0]  length;
    } entry_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

@@ hdl/radio_frame_checker_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_frame_checker_core
// Byte-stream radio frame checker: header checks, payload pass-through and a
// CRC-16/CCITT-FALSE verdict on the end byte.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake        | content
//  s_*      | in  | tvalid/tready    | tdata[7:0] rx_byte, tlast end_of_frame
//  m_*      | out | tvalid/tready    | tuser is_verdict, tdata result fields
//  cfg_*    | in  | cfg_we           | cfg_index register, cfg_data value
//
// One byte a cycle while the queue is not full; the front classifies accepted
// bytes into the queue, then the back CRC step registers the output item.
// The CRC byte step in the back end is the per-cycle limit.
// Reset clears frame state, the queue and the output; registers take defaults.
// A stalled output fills the queue; s_tready drops only once it is full.
// ----------------------------------------------------------------------------
module radio_frame_checker_core
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rfc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [7:0]                     s_tdata,   // [7:0] rx_byte
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [16] frame_ok,
    // [20:17] error_code, [28:21] frame_type, [36:29] frame_source,
    // [52:37] sequence_res, [60:53] frame_length, [63:61] zero
    output logic [rfc_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tuser    // [0] is_verdict
);

    logic            q_full, q_push, q_pop, q_valid;
    rfc_pkg::entry_t push_entry, pop_entry;

    rfc_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .q_full     (q_full),
        .push       (q_push),
        .push_entry (push_entry)
    );

    rfc_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (q_pop),
        .valid      (q_valid),
        .pop_entry  (pop_entry)
    );

    rfc_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_entry    (pop_entry),
        .q_pop      (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

@@ hdl/rfc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_front
// Takes frame bytes, tracks position and header checks, classifies each byte.
// ----------------------------------------------------------------------------
module rfc_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rfc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,
    input  logic                          s_tlast,
    input  logic                          q_full,
    output logic                          push,
    output rfc_pkg::entry_t               push_entry
);

    logic [7:0] version_reg, type_lo_reg, type_hi_reg;
    logic [7:0] src_a_reg, src_b_reg, max_pay_reg;

    logic [7:0]         pos_reg, pos_next;
    logic               ovf_reg, ovf_next;
    rfc_pkg::err_code_t herr_reg, herr_next;
    logic [7:0]         type_reg, type_next;
    logic [7:0]         src_reg, src_next;
    logic [15:0]        seq_reg, seq_next;
    logic [7:0]         len_reg, len_next;
    logic [7:0]         crcl_reg, crcl_next;

    logic       accept;
    logic [8:0] crc_start;
    logic [8:0] total;
    logic       feed;
    logic       emit;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            version_reg <= 8'd1;
            type_lo_reg <= 8'd0;
            type_hi_reg <= 8'd5;
            src_a_reg   <= 8'd0;
            src_b_reg   <= 8'd1;
            max_pay_reg <= 8'd64;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rfc_pkg::CFG_PROTOCOL_VERSION: version_reg <= cfg_data;
                rfc_pkg::CFG_TYPE_LOWEST:      type_lo_reg <= cfg_data;
                rfc_pkg::CFG_TYPE_HIGHEST:     type_hi_reg <= cfg_data;
                rfc_pkg::CFG_SOURCE_FIRST:     src_a_reg   <= cfg_data;
                rfc_pkg::CFG_SOURCE_SECOND:    src_b_reg   <= cfg_data;
                rfc_pkg::CFG_MAX_PAYLOAD:      max_pay_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        ovf_next   = ovf_reg;
        herr_next  = herr_reg;
        type_next  = type_reg;
        src_next   = src_reg;
        seq_next   = seq_reg;
        len_next   = len_reg;
        crcl_next  = crcl_reg;
        feed       = 1'b0;
        emit       = 1'b0;
        total      = 9'd0;
        crc_start  = {1'b0, rfc_pkg::HEADER_BYTES} + {1'b0, len_reg};
        push_entry = '0;

        if (accept)
        begin
            if (pos_reg == 8'hFF)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                // only the first error of the header is kept
                unique case (pos_reg)
                    8'd0:
                    begin
                        if (s_tdata != rfc_pkg::MAGIC_FIRST && herr_next == rfc_pkg::ERR_NONE)
                            herr_next = rfc_pkg::ERR_MAGIC;
                    end
                    8'd1:
                    begin
                        if (s_tdata != rfc_pkg::MAGIC_SECOND && herr_next == rfc_pkg::ERR_NONE)
                            herr_next = rfc_pkg::ERR_MAGIC;
                    end
                    8'd2:
                    begin
                        if (s_tdata != version_reg && herr_next == rfc_pkg::ERR_NONE)
                            herr_next = rfc_pkg::ERR_VERSION;
                    end
                    8'd3:
                    begin
                        type_next = s_tdata;
                        if ((s_tdata < type_lo_reg || s_tdata > type_hi_reg)
                            && herr_next == rfc_pkg::ERR_NONE)
                            herr_next = rfc_pkg::ERR_TYPE;
                    end
                    8'd4:
                    begin
                        src_next = s_tdata;
                        if (s_tdata != src_a_reg && s_tdata != src_b_reg
                            && herr_next == rfc_pkg::ERR_NONE)
                            herr_next = rfc_pkg::ERR_SOURCE;
                    end
                    8'd5: seq_next[7:0]  = s_tdata;
                    8'd6: seq_next[15:8] = s_tdata;
                    8'd7:
                    begin
                        len_next = s_tdata;
                        if (s_tdata > max_pay_reg && herr_next == rfc_pkg::ERR_NONE)
                            herr_next = rfc_pkg::ERR_PAYLOAD_LONG;
                    end
                    default: ;
                endcase

                // header is always below crc_start, so one compare covers both
                feed = ({1'b0, pos_reg} < crc_start);
                emit = feed && (pos_reg >= rfc_pkg::HEADER_BYTES) && !s_tlast;
                if (!feed && ({1'b0, pos_reg} == crc_start))
                    crcl_next = s_tdata;
                pos_next = pos_reg + 8'd1;
            end

            push_entry.data     = s_tdata;
            push_entry.feed_crc = feed;
            push_entry.emit     = emit;
            push_entry.index    = pos_reg - rfc_pkg::HEADER_BYTES;
            push_entry.is_end   = s_tlast;

            if (s_tlast)
            begin
                total = ovf_next ? rfc_pkg::FULL_COUNT : {1'b0, pos_next};
                priority if (total < rfc_pkg::MIN_FRAME)
                    push_entry.code = rfc_pkg::ERR_SHORT;
                else if (herr_next != rfc_pkg::ERR_NONE)
                    push_entry.code = herr_next;
                else if (ovf_next || total != rfc_pkg::MIN_FRAME + {1'b0, len_next})
                    push_entry.code = rfc_pkg::ERR_LENGTH;
                else
                    push_entry.code = rfc_pkg::ERR_NONE;
                push_entry.index        = 8'd0;
                push_entry.crc_low      = crcl_next;
                push_entry.frame_type   = type_next;
                push_entry.frame_source = src_next;
                push_entry.sequence_no  = seq_next;
                push_entry.length       = len_next;

                pos_next  = 8'd0;
                ovf_next  = 1'b0;
                herr_next = rfc_pkg::ERR_NONE;
                type_next = 8'd0;
                src_next  = 8'd0;
                seq_next  = 16'd0;
                len_next  = 8'd0;
                crcl_next = 8'd0;
            end
        end
    end

    // saturated bytes that do not end the frame leave nothing for the back end
    assign push = accept && (feed || s_tlast);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= 8'd0;
            ovf_reg  <= 1'b0;
            herr_reg <= rfc_pkg::ERR_NONE;
            type_reg <= 8'd0;
            src_reg  <= 8'd0;
            seq_reg  <= 16'd0;
            len_reg  <= 8'd0;
            crcl_reg <= 8'd0;
        end
        else
        begin
            pos_reg  <= pos_next;
            ovf_reg  <= ovf_next;
            herr_reg <= herr_next;
            type_reg <= type_next;
            src_reg  <= src_next;
            seq_reg  <= seq_next;
            len_reg  <= len_next;
            crcl_reg <= crcl_next;
        end
    end

endmodule

@@ hdl/rfc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_queue
// Small register FIFO of classified bytes between front and back.
// ----------------------------------------------------------------------------
module rfc_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rfc_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output logic            valid,
    output rfc_pkg::entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    rfc_pkg::entry_t  mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full      = (cnt_reg == FULL_CNT);
    assign valid     = (cnt_reg != '0);
    assign pop_entry = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

@@ hdl/rfc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfc_back
// Runs the CRC over queued bytes, settles the verdict, holds the output item.
// ----------------------------------------------------------------------------
module rfc_back
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  rfc_pkg::entry_t                q_entry,
    output logic                           q_pop,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rfc_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic                           m_tuser
);

    logic [15:0]                    crc_reg, crc_next;
    logic                           out_valid_reg, out_valid_next;
    logic [rfc_pkg::OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                           out_user_reg, out_user_next;

    logic [15:0]        crc_after;
    logic               produces;
    rfc_pkg::err_code_t code;

    assign crc_after = q_entry.feed_crc ? rfc_pkg::crc_byte(crc_reg, q_entry.data) : crc_reg;
    assign produces  = q_entry.emit || q_entry.is_end;
    assign q_pop     = q_valid && (!produces || !out_valid_reg || m_tready);

    always_comb
    begin
        code = q_entry.code;
        if (code == rfc_pkg::ERR_NONE && crc_after != {q_entry.data, q_entry.crc_low})
            code = rfc_pkg::ERR_CRC;
    end

    always_comb
    begin
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_user_next  = out_user_reg;
        if (q_pop)
        begin
            crc_next = q_entry.is_end ? rfc_pkg::CRC_INIT : crc_after;
            if (q_entry.is_end)
            begin
                out_valid_next = 1'b1;
                out_user_next  = 1'b1;
                out_data_next  = {3'b000, q_entry.length, q_entry.sequence_no,
                                  q_entry.frame_source, q_entry.frame_type,
                                  code, (code == rfc_pkg::ERR_NONE), 8'd0, 8'd0};
            end
            else if (q_entry.emit)
            begin
                out_valid_next = 1'b1;
                out_user_next  = 1'b0;
                out_data_next  = {48'd0, q_entry.index, q_entry.data};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg       <= rfc_pkg::CRC_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_user_reg <= out_user_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_ok_matches_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_user_reg |-> out_data_reg[16] == (out_data_reg[20:17] == 4'd0))
        else $error("frame_ok disagrees with error code");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_user_reg |-> out_data_reg[63:16] == 48'd0)
        else $error("payload item carries verdict fields");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    a_crc_restart: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && q_entry.is_end |=> crc_reg == rfc_pkg::CRC_INIT)
        else $error("CRC not restarted after verdict");

endmodule

@@ test/radio_frame_checker_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_frame_checker_core_tb
// Self-checking bench for the radio frame checker. A behavioural tracker
// follows every accepted byte (header checks, running CRC, saturating byte
// count) and queues the payload items and verdicts it predicts; a monitor
// compares each output item field by field. Directed frames cover every
// error code, register extremes, register changes inside a frame and
// over-long frames; random frames follow under four idling phases.
// ----------------------------------------------------------------------------
module radio_frame_checker_core_tb;

    localparam int IDLE_LIMIT = 2000;   // cycles with no handshake before giving up
    localparam int SETTLE     = 12;     // pipeline plus queue, with margin

    typedef logic [7:0] octet_q_t[$];

    typedef struct packed {
        logic                is_verdict;
        logic [7:0]          payload_byte;
        logic [7:0]          payload_index;
        logic                frame_ok;
        rfc_pkg::err_code_t  error_code;
        logic [7:0]          frame_type;
        logic [7:0]          frame_source;
        logic [15:0]         sequence_res;
        logic [7:0]          frame_length;
    } frame_out_t;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           cfg_we    = 1'b0;
    logic [rfc_pkg::CFG_IDX_W-1:0]  cfg_index = rfc_pkg::CFG_PROTOCOL_VERSION;
    logic [7:0]                     cfg_data  = 8'h00;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [7:0]                     s_tdata   = 8'h00;   // [7:0] rx_byte
    logic                           s_tlast   = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    // [7:0] payload_byte, [15:8] payload_index, [16] frame_ok, [20:17] error_code,
    // [28:21] frame_type, [36:29] frame_source, [52:37] sequence_res,
    // [60:53] frame_length, [63:61] zero
    logic [rfc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tuser;             // [0] is_verdict

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int fail_count    = 0;
    int idle_cycles   = 0;

    // register copies
    logic [7:0] reg_version  = 8'd1;
    logic [7:0] reg_type_lo  = 8'd0;
    logic [7:0] reg_type_hi  = 8'd5;
    logic [7:0] reg_src_a    = 8'd0;
    logic [7:0] reg_src_b    = 8'd1;
    logic [7:0] reg_max_len  = 8'd64;

    // frame tracking state
    logic [7:0]         frame_pos   = 8'd0;
    logic               frame_ovf   = 1'b0;
    logic [15:0]        frame_crc   = rfc_pkg::CRC_INIT;
    rfc_pkg::err_code_t hdr_err     = rfc_pkg::ERR_NONE;
    logic [7:0]         hold_type   = 8'd0;
    logic [7:0]         hold_src    = 8'd0;
    logic [15:0]        hold_seq    = 16'd0;
    logic [7:0]         hold_len    = 8'd0;
    logic [7:0]         crc_lo_rx   = 8'd0;

    frame_out_t frame_out_q[$];

    radio_frame_checker_core dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // tracker
    // ------------------------------------------------------------------------
    function automatic logic [15:0] crc16_step(logic [15:0] c, logic [7:0] b);
        logic fb;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[15] ^ b[k];
            c  = {c[14:0], 1'b0} ^ (fb ? rfc_pkg::CRC_POLY : 16'h0000);
        end
        return c;
    endfunction

    function automatic void note_header_error(rfc_pkg::err_code_t code);
        if (hdr_err == rfc_pkg::ERR_NONE)
            hdr_err = code;
    endfunction

    function automatic void track_frame_byte(logic [7:0] b, logic last);
        int         p;
        int         crc_start;
        int         total;
        frame_out_t item;
        p         = int'(frame_pos);
        crc_start = int'(rfc_pkg::HEADER_BYTES) + int'(hold_len);
        item      = '0;
        if (p == 255)
        begin
            frame_ovf = 1'b1;   // saturated: byte neither passed on nor fed to the CRC
        end
        else
        begin
            case (p)
                0: if (b != rfc_pkg::MAGIC_FIRST) note_header_error(rfc_pkg::ERR_MAGIC);
                1: if (b != rfc_pkg::MAGIC_SECOND) note_header_error(rfc_pkg::ERR_MAGIC);
                2: if (b != reg_version) note_header_error(rfc_pkg::ERR_VERSION);
                3:
                begin
                    hold_type = b;
                    if (b < reg_type_lo || b > reg_type_hi)
                        note_header_error(rfc_pkg::ERR_TYPE);
                end
                4:
                begin
                    hold_src = b;
                    if (b != reg_src_a && b != reg_src_b)
                        note_header_error(rfc_pkg::ERR_SOURCE);
                end
                5: hold_seq[7:0]  = b;
                6: hold_seq[15:8] = b;
                7:
                begin
                    hold_len = b;
                    if (b > reg_max_len) note_header_error(rfc_pkg::ERR_PAYLOAD_LONG);
                end
                default: ;
            endcase
            if (p < int'(rfc_pkg::HEADER_BYTES) || p < crc_start)
            begin
                frame_crc = crc16_step(frame_crc, b);
                if (p >= int'(rfc_pkg::HEADER_BYTES) && !last)
                begin
                    item.payload_byte  = b;
                    item.payload_index = 8'(p - int'(rfc_pkg::HEADER_BYTES));
                    frame_out_q.push_back(item);
                    frame_pos = 8'(p + 1);
                    return;
                end
            end
            else if (p == crc_start)
            begin
                crc_lo_rx = b;
            end
            frame_pos = 8'(p + 1);
        end
        if (!last)
            return;

        total = frame_ovf ? int'(rfc_pkg::FULL_COUNT) : int'(frame_pos);
        item.is_verdict = 1'b1;
        if (total < int'(rfc_pkg::MIN_FRAME))
            item.error_code = rfc_pkg::ERR_SHORT;
        else if (hdr_err != rfc_pkg::ERR_NONE)
            item.error_code = hdr_err;
        else if (frame_ovf || total != int'(rfc_pkg::MIN_FRAME) + int'(hold_len))
            item.error_code = rfc_pkg::ERR_LENGTH;
        else if (frame_crc != {b, crc_lo_rx})
            item.error_code = rfc_pkg::ERR_CRC;
        else
            item.error_code = rfc_pkg::ERR_NONE;
        item.frame_ok     = (item.error_code == rfc_pkg::ERR_NONE);
        item.frame_type   = hold_type;
        item.frame_source = hold_src;
        item.sequence_res = hold_seq;
        item.frame_length = hold_len;
        frame_out_q.push_back(item);

        frame_pos = 8'd0;
        frame_ovf = 1'b0;
        frame_crc = rfc_pkg::CRC_INIT;
        hdr_err   = rfc_pkg::ERR_NONE;
        hold_type = 8'd0;
        hold_src  = 8'd0;
        hold_seq  = 16'd0;
        hold_len  = 8'd0;
        crc_lo_rx = 8'd0;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        fail_count++;
        // keep the log short once things have clearly gone wrong
        if (fail_count <= 100)
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    task automatic check_frame_out();
        frame_out_t got;
        frame_out_t want;
        got.is_verdict    = m_tuser;
        got.payload_byte  = m_tdata[7:0];
        got.payload_index = m_tdata[15:8];
        got.frame_ok      = m_tdata[16];
        got.error_code    = rfc_pkg::err_code_t'(m_tdata[20:17]);
        got.frame_type    = m_tdata[28:21];
        got.frame_source  = m_tdata[36:29];
        got.sequence_res  = m_tdata[52:37];
        got.frame_length  = m_tdata[60:53];
        if (frame_out_q.size() == 0)
        begin
            report_mismatch("item with nothing expected", m_tdata[15:0], 16'h0000);
            return;
        end
        want = frame_out_q.pop_front();
        if (got.is_verdict !== want.is_verdict)
            report_mismatch("is_verdict", 16'(got.is_verdict), 16'(want.is_verdict));
        if (got.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
        if (got.payload_index !== want.payload_index)
            report_mismatch("payload_index", 16'(got.payload_index),
                            16'(want.payload_index));
        if (got.frame_ok !== want.frame_ok)
            report_mismatch("frame_ok", 16'(got.frame_ok), 16'(want.frame_ok));
        if (got.error_code !== want.error_code)
            report_mismatch("error_code", 16'(got.error_code), 16'(want.error_code));
        if (got.frame_type !== want.frame_type)
            report_mismatch("frame_type", 16'(got.frame_type), 16'(want.frame_type));
        if (got.frame_source !== want.frame_source)
            report_mismatch("frame_source", 16'(got.frame_source), 16'(want.frame_source));
        if (got.sequence_res !== want.sequence_res)
            report_mismatch("sequence_res", got.sequence_res, want.sequence_res);
        if (got.frame_length !== want.frame_length)
            report_mismatch("frame_length", 16'(got.frame_length), 16'(want.frame_length));
        if (m_tdata[63:61] !== 3'b000)
            report_mismatch("tdata padding", 16'(m_tdata[63:61]), 16'h0000);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_frame_out();
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("** radio_frame_checker_core: FAILED **");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers; all start and end at a falling edge
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        track_frame_byte(b, last);
        @(negedge clk);
    endtask

    // hi < 0 runs to the end of the frame; tlast only on the final byte
    task automatic send_frame(input octet_q_t f, input int lo = 0, input int hi = -1);
        int stop;
        stop = (hi < 0) ? f.size() - 1 : hi;
        for (int i = lo; i <= stop; i++)
            send_byte(f[i], i == f.size() - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (frame_out_q.size() != 0)
            @(negedge clk);
        // header and CRC low bytes give no item; header bytes may still be in flight
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [rfc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        case (idx)
            rfc_pkg::CFG_PROTOCOL_VERSION: reg_version = value;
            rfc_pkg::CFG_TYPE_LOWEST:      reg_type_lo = value;
            rfc_pkg::CFG_TYPE_HIGHEST:     reg_type_hi = value;
            rfc_pkg::CFG_SOURCE_FIRST:     reg_src_a   = value;
            rfc_pkg::CFG_SOURCE_SECOND:    reg_src_b   = value;
            rfc_pkg::CFG_MAX_PAYLOAD:      reg_max_len = value;
            default: ;
        endcase
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic write_all_regs(input logic [7:0] ver, input logic [7:0] tlo,
                                  input logic [7:0] thi, input logic [7:0] sa,
                                  input logic [7:0] sb, input logic [7:0] maxlen);
        write_reg(rfc_pkg::CFG_PROTOCOL_VERSION, ver);
        write_reg(rfc_pkg::CFG_TYPE_LOWEST, tlo);
        write_reg(rfc_pkg::CFG_TYPE_HIGHEST, thi);
        write_reg(rfc_pkg::CFG_SOURCE_FIRST, sa);
        write_reg(rfc_pkg::CFG_SOURCE_SECOND, sb);
        write_reg(rfc_pkg::CFG_MAX_PAYLOAD, maxlen);
    endtask

    function automatic octet_q_t make_frame(logic [7:0] ver, logic [7:0] typ,
                                            logic [7:0] src, logic [15:0] seq,
                                            logic [7:0] len_byte, int pay_count);
        octet_q_t f;
        f = '{rfc_pkg::MAGIC_FIRST, rfc_pkg::MAGIC_SECOND, ver, typ, src,
              seq[7:0], seq[15:8], len_byte};
        repeat (pay_count) f.push_back(8'($urandom));
        return f;
    endfunction

    function automatic octet_q_t with_crc(octet_q_t f);
        logic [15:0] c;
        c = rfc_pkg::CRC_INIT;
        foreach (f[i])
            c = crc16_step(c, f[i]);
        f.push_back(c[7:0]);
        f.push_back(c[15:8]);
        return f;
    endfunction

    function automatic octet_q_t random_frame();
        octet_q_t   f;
        int         lim;
        int         len;
        int         mode;
        int         k;
        logic [7:0] typ;
        logic [7:0] src;
        lim = (reg_max_len < 20) ? int'(reg_max_len) : 20;
        len = ($urandom_range(15) == 0) ? $urandom_range(int'(reg_max_len), 0)
                                        : $urandom_range(lim, 0);
        typ = (reg_type_lo <= reg_type_hi) ? 8'($urandom_range(reg_type_hi, reg_type_lo))
                                           : 8'($urandom);
        src = $urandom_range(1) ? reg_src_a : reg_src_b;
        f    = with_crc(make_frame(reg_version, typ, src, 16'($urandom), 8'(len), len));
        mode = $urandom_range(99);
        if (mode < 65)
        begin
            // well formed
        end
        else if (mode < 75)
        begin
            k    = $urandom_range(f.size() - 1, 0);
            f[k] = f[k] ^ 8'($urandom_range(255, 1));
        end
        else if (mode < 82)
        begin
            f = f[0:$urandom_range(f.size() - 2, 0)];
        end
        else if (mode < 88)
        begin
            repeat ($urandom_range(4, 1)) f.push_back(8'($urandom));
        end
        else if (mode < 94)
        begin
            f[7] = 8'($urandom);
        end
        else
        begin
            f = {};
            repeat ($urandom_range(20, 1)) f.push_back(8'($urandom));
        end
        return f;
    endfunction

    task automatic randomise_registers();
        logic [7:0] tlo;
        logic [7:0] thi;
        tlo = 8'($urandom_range(200, 0));
        thi = tlo + 8'($urandom_range(55, 0));
        if ($urandom_range(7) == 0)
            write_all_regs(8'($urandom), thi, tlo, 8'($urandom), 8'($urandom),
                           8'($urandom_range(245, 0)));
        else
            write_all_regs(8'($urandom), tlo, thi, 8'($urandom), 8'($urandom),
                           8'($urandom_range(245, 0)));
    endtask

    task automatic set_idling(input int send_pct, input int stall);
        send_idle_pct = send_pct;
        stall_pct     = stall;
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_header_checks();
        octet_q_t f;
        send_frame(with_crc(make_frame(8'd1, 8'd0, 8'd0, 16'h0000, 8'd0, 0)));
        f = make_frame(8'd1, 8'd5, 8'd1, 16'hFFFF, 8'd3, 0);
        f.push_back(8'h00);
        f.push_back(8'hFF);
        f.push_back(8'hA5);
        send_frame(with_crc(f));
        f = make_frame(8'd1, 8'd2, 8'd0, 16'h1234, 8'd2, 2);
        f[0] = 8'h00;
        send_frame(with_crc(f));
        f = make_frame(8'd1, 8'd2, 8'd0, 16'h1234, 8'd2, 2);
        f[1] = 8'hFF;
        send_frame(with_crc(f));
        // version and type both wrong: version wins
        send_frame(with_crc(make_frame(8'd2, 8'd9, 8'd1, 16'h00FF, 8'd1, 1)));
        send_frame(with_crc(make_frame(8'd1, 8'd6, 8'd1, 16'hFF00, 8'd1, 1)));
        send_frame(with_crc(make_frame(8'd1, 8'd3, 8'd2, 16'h5A5A, 8'd1, 1)));
        send_frame(with_crc(make_frame(8'd1, 8'd3, 8'd0, 16'hA5A5, 8'd65, 65)));
        send_frame(with_crc(make_frame(8'd1, 8'd3, 8'd0, 16'h0001, 8'd2, 3)));
        // declared payload longer than what arrives; end mark on a payload byte
        send_frame(with_crc(make_frame(8'd1, 8'd3, 8'd0, 16'h8000, 8'd4, 1)));
        f = with_crc(make_frame(8'd1, 8'd4, 8'd1, 16'h7FFF, 8'd5, 5));
        f[f.size() - 1] = ~f[f.size() - 1];
        send_frame(f);
        f = '{rfc_pkg::MAGIC_FIRST};
        send_frame(f);
        send_frame(make_frame(8'd1, 8'd0, 8'd0, 16'h0000, 8'd0, 1));
        f = make_frame(8'd7, 8'd0, 8'd0, 16'h0000, 8'd0, 0);
        f[0] = 8'hFF;
        send_frame(with_crc(f));
        f = {};
        repeat (10) f.push_back(8'hFF);
        send_frame(f);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        write_all_regs(8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0);
        send_frame(with_crc(make_frame(8'd0, 8'd255, 8'd255, 16'hBEEF, 8'd0, 0)));
        send_frame(with_crc(make_frame(8'd0, 8'd0, 8'd0, 16'h0000, 8'd0, 0)));
        send_frame(with_crc(make_frame(8'd0, 8'd7, 8'd1, 16'h0000, 8'd1, 1)));
        wait_drained();
        // inverted type range rejects everything
        write_all_regs(8'd255, 8'd255, 8'd0, 8'd17, 8'd17, 8'd245);
        send_frame(with_crc(make_frame(8'd255, 8'd0, 8'd17, 16'h0102, 8'd2, 2)));
        send_frame(with_crc(make_frame(8'd255, 8'd255, 8'd17, 16'h0304, 8'd2, 2)));
        wait_drained();
        write_reg(rfc_pkg::CFG_TYPE_HIGHEST, 8'd255);
        send_frame(with_crc(make_frame(8'd255, 8'd255, 8'd17, 16'h0506, 8'd3, 3)));
        send_frame(with_crc(make_frame(8'd255, 8'd254, 8'd17, 16'h0708, 8'd3, 3)));
        wait_drained();
    endtask

    task automatic test_mid_frame_config();
        octet_q_t f;
        write_all_regs(8'd3, 8'd10, 8'd12, 8'd0, 8'd1, 8'd64);
        f = with_crc(make_frame(8'd3, 8'd11, 8'd1, 16'hC0DE, 8'd4, 4));
        send_frame(f, 0, 2);
        wait_drained();
        write_reg(rfc_pkg::CFG_PROTOCOL_VERSION, 8'd9);
        send_frame(f, 3, 4);
        wait_drained();
        write_reg(rfc_pkg::CFG_TYPE_LOWEST, 8'd100);
        write_reg(rfc_pkg::CFG_TYPE_HIGHEST, 8'd100);
        send_frame(f, 5);
        wait_drained();
        // range moved before the type byte arrives
        write_all_regs(8'd9, 8'd10, 8'd12, 8'd0, 8'd1, 8'd64);
        f = with_crc(make_frame(8'd9, 8'd11, 8'd0, 16'h0042, 8'd2, 2));
        send_frame(f, 0, 2);
        wait_drained();
        write_reg(rfc_pkg::CFG_TYPE_LOWEST, 8'd0);
        write_reg(rfc_pkg::CFG_TYPE_HIGHEST, 8'd5);
        send_frame(f, 3);
        wait_drained();
    endtask

    task automatic test_overflow();
        write_all_regs(8'd1, 8'd0, 8'd5, 8'd0, 8'd1, 8'd245);
        // longest legal frame: exactly 255 bytes
        send_frame(with_crc(make_frame(8'd1, 8'd2, 8'd1, 16'hFEED, 8'd245, 245)));
        send_frame(with_crc(make_frame(8'd1, 8'd2, 8'd1, 16'h0246, 8'd245, 246)));
        send_frame(with_crc(make_frame(8'd1, 8'd2, 8'd0, 16'h1357, 8'd200, 250)));
        send_frame(with_crc(make_frame(8'd1, 8'd2, 8'd0, 16'hFFFF, 8'd255, 255)));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int byte_budget);
        octet_q_t f;
        int       sent;
        sent = 0;
        randomise_registers();
        while (sent < byte_budget)
        begin
            f     = random_frame();
            sent += f.size();
            send_frame(f);
            if ($urandom_range(11) == 0)
            begin
                wait_drained();
                randomise_registers();
            end
        end
        wait_drained();
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling(0, 0);
        test_header_checks();
        set_idling(70, 0);
        test_register_extremes();
        set_idling(0, 70);
        test_mid_frame_config();
        set_idling(22, 22);
        test_overflow();

        set_idling(0, 0);
        test_random_traffic(60);
        set_idling(70, 0);
        test_random_traffic(60);
        set_idling(0, 70);
        test_random_traffic(60);
        set_idling(22, 22);
        test_random_traffic(60);

        wait_drained();
        if (fail_count == 0)
            $display("** radio_frame_checker_core: PASSED **");
        else
            $display("** radio_frame_checker_core: FAILED **");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/rfc_pkg.sv
hdl/rfc_front.sv
hdl/rfc_queue.sv
hdl/rfc_back.sv
hdl/radio_frame_checker_core.sv
test/radio_frame_checker_core_tb.sv
